/* sv/tsv_pkg.sv */
package tsv_pkg;

  localparam int STARS    = 256;
  localparam int STAR_AW  = $clog2(STARS);
  localparam int VOTE_AW  = 2 * STAR_AW;
  localparam int TRI_MAX  = 4096;
  localparam int TRI_AW   = $clog2(TRI_MAX);
  localparam int CNT_W    = TRI_AW + 1;

  localparam logic [8:0]  STAR_LIM  = 9'(STARS);
  localparam logic [15:0] VOTE_CAP  = 16'hFFFF;
  localparam logic [12:0] MATCH_CAP = 13'h1FFF;

  // register indexes
  localparam logic [2:0] REG_RADIUS    = 3'd0;
  localparam logic [2:0] REG_SCALE_MIN = 3'd1;
  localparam logic [2:0] REG_SCALE_MAX = 3'd2;
  localparam logic [2:0] REG_IMG_CNT   = 3'd3;
  localparam logic [2:0] REG_CAT_CNT   = 3'd4;

  // result status codes
  localparam logic [1:0] STS_DONE = 2'd0;
  localparam logic [1:0] STS_FULL = 2'd1;
  localparam logic [1:0] STS_OOB  = 2'd2;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_MATCH = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [16:0] ratio_ba;
    logic [16:0] ratio_ca;
    logic [23:0] longest_side;
    logic [7:0]  vertex_opposite_longest;
    logic [7:0]  vertex_opposite_middle;
    logic [7:0]  vertex_opposite_shortest;
    logic [7:0]  read_image_star;
    logic [7:0]  read_catalog_star;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] vote_count;
    logic [12:0] matches_found;
  } out_item_t;

  // decoded job handed from front to back
  typedef struct packed {
    cmd_e        op;
    logic [16:0] ba;
    logic [16:0] ca;
    logic [23:0] side;
    logic [2:0][7:0] vert;
    logic [VOTE_AW-1:0] rd_addr;
    logic        rd_oob;
  } job_t;

  typedef struct packed {
    logic        valid;
    logic [2:0]  index;
    logic [23:0] data;
  } cfg_wr_t;

endpackage

/* sv/tsv_front.sv */
module tsv_front
  import tsv_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  in_item_t in_item_i,
  output logic     job_valid_o,
  output job_t     job_o,
  input  logic     job_pop_i
);

  job_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;
  logic       wr_en, rd_en;
  job_t       job_d;

  // decode one item into a job
  always_comb begin
    job_d.op      = cmd_e'(in_item_i.command);
    job_d.ba      = in_item_i.ratio_ba;
    job_d.ca      = in_item_i.ratio_ca;
    job_d.side    = in_item_i.longest_side;
    job_d.vert[0] = in_item_i.vertex_opposite_longest;
    job_d.vert[1] = in_item_i.vertex_opposite_middle;
    job_d.vert[2] = in_item_i.vertex_opposite_shortest;
    job_d.rd_addr = {in_item_i.read_image_star[STAR_AW-1:0],
                     in_item_i.read_catalog_star[STAR_AW-1:0]};
    job_d.rd_oob  = ({1'b0, in_item_i.read_image_star} >= STAR_LIM) ||
                    ({1'b0, in_item_i.read_catalog_star} >= STAR_LIM);
  end

  assign full        = (fill_q == 2'd2);
  assign wr_en       = push && !full;
  assign job_valid_o = (fill_q != 2'd0);
  assign rd_en       = job_pop_i && job_valid_o;
  assign job_o       = slot_q[rd_ptr_q];

  // hold decoded beats
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_q[wr_ptr_q] <= job_d;
    end
  end

  // advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (wr_en) wr_ptr_q <= !wr_ptr_q;
      if (rd_en) rd_ptr_q <= !rd_ptr_q;
      fill_q <= fill_q + 2'(wr_en) - 2'(rd_en);
    end
  end

endmodule

/* sv/tsv_back.sv */
module tsv_back
  import tsv_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_wr_t   cfg_i,
  input  logic      job_valid_i,
  input  job_t      job_i,
  output logic      job_pop_o,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item_o
);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_SETUP, ST_SETUP2, ST_SCAN,
    ST_VRD, ST_VWR, ST_RDWAIT, ST_DONE
  } state_e;

  state_e state_q;

  // configuration registers
  logic [15:0] radius_q;
  logic [23:0] smin_q, smax_q;
  logic [8:0]  img_cnt_q, cat_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q  <= 16'd131;
      smin_q    <= '0;
      smax_q    <= '0;
      img_cnt_q <= STAR_LIM;
      cat_cnt_q <= STAR_LIM;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_RADIUS:    radius_q  <= cfg_i.data[15:0];
        REG_SCALE_MIN: smin_q    <= cfg_i.data;
        REG_SCALE_MAX: smax_q    <= cfg_i.data;
        REG_IMG_CNT:   img_cnt_q <= cfg_i.data[8:0];
        REG_CAT_CNT:   cat_cnt_q <= cfg_i.data[8:0];
        default: ;
      endcase
    end
  end

  job_t               cur_q;
  logic [CNT_W-1:0]   count_q, k_q;
  logic [VOTE_AW-1:0] clr_q;
  logic               clr_reply_q;
  logic [1:0]         pair_q;
  logic [12:0]        found_q;
  logic [1:0]         status_q;
  logic [15:0]        vote_q;
  logic               out_valid_q;
  out_item_t          out_q;

  // triangle store
  logic [33:0] shape_mem [TRI_MAX];
  logic [47:0] geo_mem   [TRI_MAX];
  logic [33:0] shape_rd_q;
  logic [47:0] geo_rd_q;
  logic        tri_we, adv, issue, hit;

  assign tri_we = (state_q == ST_IDLE) && job_valid_i && (job_i.op == CMD_LOAD) &&
                  (count_q != CNT_W'(TRI_MAX));
  assign adv    = ((state_q == ST_SCAN) && !hit) ||
                  ((state_q == ST_VWR) && (pair_q == 2'd2));
  assign issue  = adv && (state_q == ST_SCAN) && (k_q < count_q);

  always_ff @(posedge clk_i) begin
    if (tri_we) begin
      shape_mem[count_q[TRI_AW-1:0]] <= {job_i.ba, job_i.ca};
      geo_mem[count_q[TRI_AW-1:0]]   <= {job_i.side, job_i.vert};
    end
    if (adv) begin
      shape_rd_q <= shape_mem[k_q[TRI_AW-1:0]];
      geo_rd_q   <= geo_mem[k_q[TRI_AW-1:0]];
    end
  end

  // scale window and radius, products split into 24x12 halves
  logic [35:0] plo0_q, plo1_q, phi0_q, phi1_q;
  logic [47:0] lo_q, hi_q;
  logic [31:0] r2_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SETUP) begin
      plo0_q <= smin_q * cur_q.side[11:0];
      plo1_q <= smin_q * cur_q.side[23:12];
      phi0_q <= smax_q * cur_q.side[11:0];
      phi1_q <= smax_q * cur_q.side[23:12];
      r2_q   <= radius_q * radius_q;
    end
    if (state_q == ST_SETUP2) begin
      lo_q <= {12'd0, plo0_q} + {plo1_q, 12'd0};
      hi_q <= {12'd0, phi0_q} + {phi1_q, 12'd0};
    end
  end

  // scan pipeline: square the shape differences
  logic        s1_v_q, s2_v_q;
  logic [16:0] db, dc;
  logic [33:0] db2_q, dc2_q;
  logic [23:0] side2_q;
  logic [2:0][7:0] vert2_q;

  always_comb begin
    db = (shape_rd_q[33:17] >= cur_q.ba) ? shape_rd_q[33:17] - cur_q.ba
                                         : cur_q.ba - shape_rd_q[33:17];
    dc = (shape_rd_q[16:0] >= cur_q.ca) ? shape_rd_q[16:0] - cur_q.ca
                                        : cur_q.ca - shape_rd_q[16:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      db2_q   <= db * db;
      dc2_q   <= dc * dc;
      side2_q <= geo_rd_q[47:24];
      vert2_q <= geo_rd_q[23:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= issue;
      s2_v_q <= s1_v_q;
    end
  end

  // match decision on the squared stage
  logic        scaled, dist_ok, scale_ok;
  logic [34:0] sq_dist;
  logic [47:0] img_side;

  always_comb begin
    sq_dist  = {1'b0, db2_q} + {1'b0, dc2_q};
    dist_ok  = sq_dist < {3'd0, r2_q};
    scaled   = (smin_q != '0) && (smax_q != '0);
    img_side = {8'd0, side2_q, 16'd0};
    scale_ok = !scaled || ((img_side >= lo_q) && (img_side <= hi_q));
    hit      = s2_v_q && dist_ok && scale_ok;
  end

  // vote matrix
  logic [15:0]        vote_mem [STARS*STARS];
  logic [15:0]        vote_rd_q;
  logic               v_we, v_re, pair_ok;
  logic [VOTE_AW-1:0] v_wa, v_ra, pair_addr;
  logic [15:0]        v_wd;
  logic [7:0]         img_v, cat_v;

  always_comb begin
    case (pair_q)
      2'd0:    begin img_v = vert2_q[2]; cat_v = cur_q.vert[2]; end
      2'd1:    begin img_v = vert2_q[1]; cat_v = cur_q.vert[1]; end
      default: begin img_v = vert2_q[0]; cat_v = cur_q.vert[0]; end
    endcase
    pair_addr = {img_v[STAR_AW-1:0], cat_v[STAR_AW-1:0]};
    pair_ok   = ({1'b0, img_v} < img_cnt_q) && ({1'b0, img_v} < STAR_LIM) &&
                ({1'b0, cat_v} < cat_cnt_q) && ({1'b0, cat_v} < STAR_LIM);
    v_we = 1'b0;
    v_wa = pair_addr;
    v_wd = vote_rd_q + 16'd1;
    v_re = 1'b0;
    v_ra = pair_addr;
    case (state_q)
      ST_CLEAR: begin
        v_we = 1'b1;
        v_wa = clr_q;
        v_wd = '0;
      end
      ST_IDLE: begin
        v_re = job_valid_i && (job_i.op == CMD_READ);
        v_ra = job_i.rd_addr;
      end
      ST_VRD: v_re = 1'b1;
      ST_VWR: v_we = pair_ok && (vote_rd_q != VOTE_CAP);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (v_we) vote_mem[v_wa] <= v_wd;
    if (v_re) vote_rd_q <= vote_mem[v_ra];
  end

  assign job_pop_o  = (state_q == ST_IDLE) && job_valid_i;
  assign empty      = !out_valid_q;
  assign out_item_o = out_q;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      clr_reply_q <= 1'b0;
      count_q     <= '0;
      k_q         <= '0;
      pair_q      <= '0;
      found_q     <= '0;
      status_q    <= STS_DONE;
      vote_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      cur_q       <= '0;
    end else begin
      if (pop && out_valid_q && (state_q != ST_DONE)) out_valid_q <= 1'b0;
      if (issue) k_q <= k_q + CNT_W'(1);
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + VOTE_AW'(1);
          if (clr_q == '1) state_q <= clr_reply_q ? ST_DONE : ST_IDLE;
        end
        ST_IDLE: begin
          if (job_valid_i) begin
            cur_q    <= job_i;
            status_q <= ((job_i.op == CMD_LOAD) && !tri_we) ? STS_FULL : STS_DONE;
            vote_q   <= '0;
            found_q  <= '0;
            case (job_i.op)
              CMD_CLEAR: begin
                count_q     <= '0;
                clr_q       <= '0;
                clr_reply_q <= 1'b1;
                state_q     <= ST_CLEAR;
              end
              CMD_LOAD: begin
                if (tri_we) count_q <= count_q + CNT_W'(1);
                state_q <= ST_DONE;
              end
              CMD_MATCH: begin
                k_q     <= '0;
                state_q <= ST_SETUP;
              end
              default: state_q <= ST_RDWAIT;
            endcase
          end
        end
        ST_SETUP:  state_q <= ST_SETUP2;
        ST_SETUP2: state_q <= ST_SCAN;
        ST_SCAN: begin
          if (hit) begin
            pair_q  <= 2'd0;
            state_q <= ST_VRD;
          end else if ((k_q == count_q) && !s1_v_q && !s2_v_q) begin
            state_q <= ST_DONE;
          end
        end
        ST_VRD: state_q <= ST_VWR;
        ST_VWR: begin
          if (pair_q == 2'd2) begin
            if (found_q != MATCH_CAP) found_q <= found_q + 13'd1;
            state_q <= ST_SCAN;
          end else begin
            pair_q  <= pair_q + 2'd1;
            state_q <= ST_VRD;
          end
        end
        ST_RDWAIT: begin
          status_q <= cur_q.rd_oob ? STS_OOB : STS_DONE;
          vote_q   <= cur_q.rd_oob ? 16'd0 : vote_rd_q;
          state_q  <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_q || pop) begin
            out_q       <= '{status: status_q, vote_count: vote_q,
                             matches_found: found_q};
            out_valid_q <= 1'b1;
            clr_reply_q <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TRI_MAX)) else $error("store count past capacity");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |-> state_q == ST_IDLE) else $error("job taken while busy");

  a_hit_votes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && hit) |=> state_q == ST_VRD)
    else $error("match did not start vote update");

  a_vrd_vwr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_VRD |=> state_q == ST_VWR)
    else $error("vote read not followed by write");

endmodule

/* sv/triangle_similarity_vote_engine_top.sv */
// Triangle match voting engine. Items go in through a push/full queue and one
// result per item comes out through an empty/pop queue. After reset the vote
// matrix is swept to zero, one entry a cycle; no job leaves the input queue until
// it ends, configuration writes are taken at any time. A clear command costs the
// same sweep. In a match the store is scanned one triangle a cycle through a
// two-stage compare, and each match stalls the scan for three read-modify-write
// updates on the single-port vote memory plus a refill of the compare pipeline.
// A two-deep job queue and a result register let the input and output sides
// stall independently.
module triangle_similarity_vote_engine_top
  import tsv_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);

  logic    job_valid, job_pop;
  job_t    job;
  cfg_wr_t cfg_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = '{valid: cfg_valid_i, index: cfg_index_i, data: cfg_data_i};

  tsv_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_pop_i   (job_pop)
  );

  tsv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_wr),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_pop_o   (job_pop),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item_o)
  );

endmodule

/* tb/tb_triangle_similarity_vote_engine_top.sv */
module tb_triangle_similarity_vote_engine_top;
  import tsv_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  in_item_t    in_item_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  out_item_t   out_item_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [23:0] cfg_data_i = '0;

  triangle_similarity_vote_engine_top dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Scoreboard: tracks store, votes and registers, predicts each result beat.
  class vote_scoreboard;
    logic [16:0] tri_ba [TRI_MAX];
    logic [16:0] tri_ca [TRI_MAX];
    logic [23:0] tri_side [TRI_MAX];
    logic [7:0]  tri_vert [TRI_MAX][3];
    int unsigned tri_count;
    logic [15:0] votes [STARS*STARS];
    logic [15:0] radius;
    logic [23:0] smin, smax;
    logic [8:0]  img_cnt, cat_cnt;
    out_item_t   pending [$];
    int          errors;

    function new();
      tri_count = 0;
      foreach (votes[i]) votes[i] = '0;
      radius = 16'd131; smin = '0; smax = '0;
      img_cnt = 9'd256; cat_cnt = 9'd256;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [23:0] val);
      case (idx)
        REG_RADIUS:    radius = val[15:0];
        REG_SCALE_MIN: smin = val;
        REG_SCALE_MAX: smax = val;
        REG_IMG_CNT:   img_cnt = val[8:0];
        REG_CAT_CNT:   cat_cnt = val[8:0];
        default: ;
      endcase
    endfunction

    function void bump_vote(logic [7:0] img, logic [7:0] cat);
      int li, lc, pos;
      li = (img_cnt < STAR_LIM) ? img_cnt : STARS;
      lc = (cat_cnt < STAR_LIM) ? cat_cnt : STARS;
      if (img >= li || cat >= lc) return;
      pos = img * STARS + cat;
      if (votes[pos] != VOTE_CAP) votes[pos]++;
    endfunction

    // Note an accepted input beat and queue its expected result.
    function void note_input(in_item_t it);
      out_item_t r;
      longint unsigned r2, lo, hi, db, dc, img;
      r = '0;
      case (cmd_e'(it.command))
        CMD_CLEAR: begin
          tri_count = 0;
          foreach (votes[i]) votes[i] = '0;
        end
        CMD_LOAD: begin
          if (tri_count >= TRI_MAX) r.status = STS_FULL;
          else begin
            tri_ba[tri_count] = it.ratio_ba;
            tri_ca[tri_count] = it.ratio_ca;
            tri_side[tri_count] = it.longest_side;
            tri_vert[tri_count][0] = it.vertex_opposite_longest;
            tri_vert[tri_count][1] = it.vertex_opposite_middle;
            tri_vert[tri_count][2] = it.vertex_opposite_shortest;
            tri_count++;
          end
        end
        CMD_MATCH: begin
          r2 = longint'(radius) * radius;
          lo = longint'(smin) * it.longest_side;
          hi = longint'(smax) * it.longest_side;
          for (int k = 0; k < tri_count; k++) begin
            db = (tri_ba[k] >= it.ratio_ba) ? tri_ba[k] - it.ratio_ba
                                            : it.ratio_ba - tri_ba[k];
            dc = (tri_ca[k] >= it.ratio_ca) ? tri_ca[k] - it.ratio_ca
                                            : it.ratio_ca - tri_ca[k];
            if (db*db + dc*dc >= r2) continue;
            if (smin != 0 && smax != 0) begin
              img = longint'(tri_side[k]) << 16;
              if (img < lo || img > hi) continue;
            end
            bump_vote(tri_vert[k][0], it.vertex_opposite_longest);
            bump_vote(tri_vert[k][1], it.vertex_opposite_middle);
            bump_vote(tri_vert[k][2], it.vertex_opposite_shortest);
            if (r.matches_found != MATCH_CAP) r.matches_found++;
          end
        end
        default: r.vote_count = votes[it.read_image_star * STARS + it.read_catalog_star];
      endcase
      pending.insert(pending.size(), r);
    endfunction

    // Compare a popped result beat with the oldest expectation.
    function void check_result(out_item_t got);
      out_item_t exp;
      if (pending.size() == 0) begin
        $error("unexpected result beat %h", got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status) begin
        $error("status: expected %0d, actual %0d", exp.status, got.status);
        errors++;
      end
      if (got.vote_count !== exp.vote_count) begin
        $error("vote_count: expected %0d, actual %0d", exp.vote_count, got.vote_count);
        errors++;
      end
      if (got.matches_found !== exp.matches_found) begin
        $error("matches_found: expected %0d, actual %0d", exp.matches_found,
               got.matches_found);
        errors++;
      end
    endfunction
  endclass

  vote_scoreboard sb = new();
  int send_idle_pct = 0;
  int pop_stall_pct = 0;
  int idle_cycles = 0;
  int n_sent = 0, n_match = 0, n_popped = 0;
  localparam int WATCHDOG = 300000;

  // Pop results and check them; count cycles without progress.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        sb.check_result(out_item_o);
        n_popped++;
      end
      if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o))
        idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(negedge clk_i) begin
    pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= WATCHDOG) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Send one item, with random idle cycles ahead of it; push stays up for
  // the next beat until an idle cycle or a drain drops it.
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.note_input(it);
    n_sent++;
    if (it.command == CMD_MATCH) n_match++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic in_item_t make_item(cmd_e op);
    in_item_t it;
    it = '0;
    it.command = op;
    it.ratio_ba = ($urandom_range(19) == 0) ? 17'($urandom) : 17'($urandom_range(65536));
    it.ratio_ca = ($urandom_range(19) == 0) ? 17'($urandom) : 17'($urandom_range(65536));
    it.longest_side = 24'($urandom);
    it.vertex_opposite_longest = 8'($urandom);
    it.vertex_opposite_middle = 8'($urandom);
    it.vertex_opposite_shortest = 8'($urandom);
    it.read_image_star = 8'($urandom);
    it.read_catalog_star = 8'($urandom);
    return it;
  endfunction

  // Load a few triangles, then match perturbed copies, reading votes after each match.
  task automatic random_group(int n_load);
    in_item_t base [$];
    in_item_t it;
    for (int i = 0; i < n_load; i++) begin
      it = make_item(CMD_LOAD);
      it.vertex_opposite_longest = 8'($urandom_range(15));
      it.vertex_opposite_middle = 8'($urandom_range(15));
      base.insert(base.size(), it);
      send_item(it);
    end
    for (int i = 0; i < 2; i++) begin
      it = base[$urandom_range(base.size()-1)];
      it.command = CMD_MATCH;
      it.ratio_ba = it.ratio_ba + 17'($urandom_range(100)) - 17'd50;
      it.longest_side = 24'($urandom_range(65535)) << 4;
      if ($urandom_range(3) == 0) it = make_item(CMD_MATCH);
      send_item(it);
      it.command = CMD_READ;
      it.read_image_star = base[0].vertex_opposite_longest;
      it.read_catalog_star = it.vertex_opposite_longest;
      send_item(it);
    end
  endtask

  task automatic random_phase(int n_groups, int sip, int psp);
    send_idle_pct = sip;
    pop_stall_pct = psp;
    for (int g = 0; g < n_groups; g++) random_group($urandom_range(1, 4));
    drain();
  endtask

  initial begin
    in_item_t it;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, every command and range corners.
    it = '0; it.command = CMD_READ; send_item(it);
    it = '0; it.command = CMD_LOAD; send_item(it);
    it = '1; it.command = CMD_LOAD; send_item(it);
    it = '0; it.command = CMD_LOAD; it.ratio_ba = 17'd65536; it.ratio_ca = 17'd65536;
    it.longest_side = 24'd256; it.vertex_opposite_longest = 8'd255;
    it.vertex_opposite_middle = 8'd1; it.vertex_opposite_shortest = 8'd2;
    send_item(it);
    it.command = CMD_MATCH; send_item(it);
    it = '0; it.command = CMD_MATCH; send_item(it);
    it = '1; it.command = CMD_MATCH; send_item(it);
    it = '0; it.command = CMD_READ; it.read_image_star = 8'd255;
    it.read_catalog_star = 8'd255; send_item(it);
    it.read_image_star = 8'd0; it.read_catalog_star = 8'd0; send_item(it);
    drain();

    // Scale test on, with a zero catalog side and a narrow window.
    write_reg(REG_RADIUS, 24'hFFFF);
    write_reg(REG_SCALE_MIN, 24'h010000);
    write_reg(REG_SCALE_MAX, 24'hFFFFFF);
    write_reg(REG_IMG_CNT, 9'd2);
    write_reg(REG_CAT_CNT, 9'd0);
    it = '0; it.command = CMD_MATCH; send_item(it);
    it.longest_side = 24'd256; send_item(it);
    it.longest_side = 24'hFFFFFF; send_item(it);
    it.command = CMD_READ; send_item(it);
    drain();
    write_reg(REG_CAT_CNT, 9'd256);
    write_reg(REG_IMG_CNT, 9'h1FF);
    write_reg(REG_SCALE_MIN, 24'd1);
    write_reg(REG_SCALE_MAX, 24'd1);
    it = '0; it.command = CMD_MATCH; send_item(it);
    it = '0; it.command = CMD_CLEAR; send_item(it);
    it.command = CMD_READ; send_item(it);
    drain();

    // Random phases over several register settings.
    write_reg(REG_SCALE_MIN, 24'd0);
    write_reg(REG_RADIUS, 24'd4000);
    random_phase(5, 0, 0);
    write_reg(REG_SCALE_MIN, 24'h008000);
    write_reg(REG_SCALE_MAX, 24'h100000);
    random_phase(5, 74, 0);
    write_reg(REG_RADIUS, 24'd0);
    write_reg(REG_SCALE_MAX, 24'd0);
    random_phase(4, 0, 74);
    write_reg(REG_RADIUS, 24'd131);
    write_reg(REG_IMG_CNT, 24'd8);
    write_reg(REG_CAT_CNT, 24'd8);
    random_phase(5, 20, 20);
    it = '0; it.command = CMD_CLEAR; send_item(it);
    drain();

    $display("covered %0d items, %0d matches, %0d results checked",
             n_sent, n_match, n_popped);
    $display("commands clear/load/match/read across five register settings");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
